// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the queue checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define QM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("queue check failed");

// next-cycle implication, off during reset
`define QM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("queue check failed");

`endif

// ===== hw/rtl/qmid_pkg.sv =====
// shared constants, request and status codes, and controller/datapath bundles
package qmid_pkg;

	localparam int unsigned DEPTH_DEFAULT = 1024;

	localparam int REQ_W   = 3;
	localparam int VALUE_W = 64;
	localparam int POS_W   = 10;
	localparam int ST_W    = 2;
	localparam int COUNT_W = 11;

	localparam logic [REQ_W-1:0] REQ_ENQ  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_DEQ  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_INS  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_DEL  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_READ = 3'd4;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic load;
		logic setup;
		logic step;
		logic finish;
	} qmid_cmd_t;

	typedef struct packed {
		logic needs_shift;
		logic at_stop;
		logic out_free;
	} qmid_sts_t;

endpackage

// ===== hw/rtl/qmid_stream_if.sv =====
// valid/ready channels for request and response items
interface qmid_req_if;
	logic                                valid;
	logic                                ready;
	logic [qmid_pkg::REQ_W-1:0]          req_type;
	logic signed [qmid_pkg::VALUE_W-1:0] value;
	logic [qmid_pkg::POS_W-1:0]          position;

	modport source (output valid, req_type, value, position, input ready);
	modport sink (input valid, req_type, value, position, output ready);
endinterface

interface qmid_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [qmid_pkg::ST_W-1:0]           status;
	logic signed [qmid_pkg::VALUE_W-1:0] read_value;
	logic [qmid_pkg::COUNT_W-1:0]        count;

	modport source (output valid, status, read_value, count, input ready);
	modport sink (input valid, status, read_value, count, output ready);
endinterface

// ===== hw/rtl/qmid_ctrl.sv =====
// request sequencer: accept, set up, shift loop, drain, result
module qmid_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  qmid_pkg::qmid_sts_t sts,
	output qmid_pkg::qmid_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_EXEC   = 5'b00010,
		S_SHIFT  = 5'b00100,
		S_DRAIN  = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.setup = 1'b1;
				state_d   = sts.needs_shift ? S_SHIFT : S_FINISH;
			end
			S_SHIFT: begin
				cmd.step = 1'b1;
				if (sts.at_stop) state_d = S_DRAIN;
			end
			// last pending write lands here
			S_DRAIN: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

// ===== hw/rtl/qmid_dp.sv =====
// storage, front/rear indices, shift cursor and output register
module qmid_dp #(
	parameter int unsigned DEPTH = qmid_pkg::DEPTH_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  qmid_pkg::qmid_cmd_t                 cmd,
	output qmid_pkg::qmid_sts_t                 sts,
	input  logic [qmid_pkg::REQ_W-1:0]          in_req_type,
	input  logic signed [qmid_pkg::VALUE_W-1:0] in_value,
	input  logic [qmid_pkg::POS_W-1:0]          in_position,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [qmid_pkg::ST_W-1:0]           out_status,
	output logic signed [qmid_pkg::VALUE_W-1:0] out_read_value,
	output logic [qmid_pkg::COUNT_W-1:0]        out_count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = (AW + 1 > qmid_pkg::COUNT_W) ? AW + 1 : qmid_pkg::COUNT_W;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [qmid_pkg::VALUE_W-1:0] mem [DEPTH];

	logic [qmid_pkg::REQ_W-1:0]   req_q;
	logic [qmid_pkg::VALUE_W-1:0] value_q;
	logic [qmid_pkg::POS_W-1:0]   pos_q;
	logic [AW-1:0]                front_q, rear_q;
	logic                         ne_q;
	logic [AW-1:0]                cursor_q, stop_q, last_ra_q;
	logic                         pend_q;
	logic [qmid_pkg::VALUE_W-1:0] rd_q;
	logic                         out_valid_q;
	logic [qmid_pkg::ST_W-1:0]    status_q;
	logic [qmid_pkg::VALUE_W-1:0] rdv_q;
	logic [qmid_pkg::COUNT_W-1:0] count_q;

	logic [AW:0]                  sum, sum1;
	logic [AW-1:0]                mid_ins, mid_del;
	logic                         full;
	logic [CW-1:0]                held;
	logic                         re, we;
	logic [AW-1:0]                ra, wa;
	logic [qmid_pkg::VALUE_W-1:0] wd;

	logic [AW-1:0]                nf, nr;
	logic                         nne;
	logic [qmid_pkg::ST_W-1:0]    st;
	logic [qmid_pkg::VALUE_W-1:0] rdv;
	logic                         fin_we;
	logic [AW-1:0]                fin_wa;
	logic [CW-1:0]                count_next;

	assign sum     = {1'b0, front_q} + {1'b0, rear_q};
	assign sum1    = sum + (AW+1)'(1);
	assign mid_ins = sum[AW:1];
	assign mid_del = sum1[AW:1];
	assign full    = ne_q && (rear_q == LAST);
	assign held    = ne_q ? (CW'(rear_q) - CW'(front_q) + CW'(1)) : '0;

	assign sts.needs_shift = ((req_q == qmid_pkg::REQ_INS) && ne_q && !full
				&& (rear_q != mid_ins))
			|| ((req_q == qmid_pkg::REQ_DEL) && ne_q && (mid_del != front_q));
	assign sts.at_stop  = (cursor_q == stop_q);
	assign sts.out_free = !out_valid_q || out_ready;

	// result of the request, from indices that the shift loop leaves alone
	always_comb begin
		nf     = front_q;
		nr     = rear_q;
		nne    = ne_q;
		st     = qmid_pkg::ST_OK;
		rdv    = '0;
		fin_we = 1'b0;
		fin_wa = '0;
		case (req_q)
			qmid_pkg::REQ_ENQ, qmid_pkg::REQ_INS: begin
				if (full) begin
					st = qmid_pkg::ST_FULL;
				end else if (!ne_q) begin
					fin_we = 1'b1;
					nf     = '0;
					nr     = '0;
					nne    = 1'b1;
				end else begin
					fin_we = 1'b1;
					fin_wa = (req_q == qmid_pkg::REQ_ENQ) ? rear_q + AW'(1)
						: mid_ins + AW'(1);
					nr     = rear_q + AW'(1);
				end
			end
			qmid_pkg::REQ_DEQ, qmid_pkg::REQ_DEL: begin
				if (!ne_q) begin
					st = qmid_pkg::ST_EMPTY;
				end else if (front_q == rear_q) begin
					nf  = '0;
					nr  = '0;
					nne = 1'b0;
				end else begin
					nf = front_q + AW'(1);
				end
			end
			qmid_pkg::REQ_READ: begin
				if (!ne_q) begin
					st = qmid_pkg::ST_EMPTY;
				end else if (CW'(pos_q) >= held) begin
					st = qmid_pkg::ST_RANGE;
				end else begin
					rdv = rd_q;
				end
			end
			default: begin
				st = qmid_pkg::ST_OK;
			end
		endcase
	end

	assign count_next = nne ? (CW'(nr) - CW'(nf) + CW'(1)) : '0;

	// one read and one write per cycle; each shift write lands one slot above its read
	always_comb begin
		re = 1'b0;
		ra = cursor_q;
		if (cmd.step) begin
			re = 1'b1;
		end else if (cmd.setup && (req_q == qmid_pkg::REQ_READ)) begin
			re = 1'b1;
			ra = AW'(CW'(front_q) + CW'(pos_q));
		end
	end

	always_comb begin
		we = 1'b0;
		wa = last_ra_q + AW'(1);
		wd = rd_q;
		if (pend_q) begin
			we = 1'b1;
		end else if (cmd.finish && fin_we) begin
			we = 1'b1;
			wa = fin_wa;
			wd = value_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (re) rd_q <= mem[ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= in_req_type;
			value_q <= in_value;
			pos_q   <= in_position;
		end
		if (cmd.setup) begin
			if (req_q == qmid_pkg::REQ_INS) begin
				cursor_q <= rear_q;
				stop_q   <= mid_ins + AW'(1);
			end else begin
				cursor_q <= mid_del - AW'(1);
				stop_q   <= front_q;
			end
		end else if (cmd.step) begin
			cursor_q <= cursor_q - AW'(1);
		end
		if (cmd.step) last_ra_q <= cursor_q;
		if (cmd.finish) begin
			status_q <= st;
			rdv_q    <= rdv;
			count_q  <= count_next[qmid_pkg::COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			rear_q      <= '0;
			ne_q        <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_q <= cmd.step;
			if (cmd.finish) begin
				front_q     <= nf;
				rear_q      <= nr;
				ne_q        <= nne;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign out_status     = status_q;
	assign out_read_value = rdv_q;
	assign out_count      = count_q;

endmodule

// ===== hw/rtl/queue_middle_insert_delete_core.sv =====
// top level of the middle insert/delete queue
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    req_type[2:0], value[63:0] signed, position[9:0]
//  rsp      out  valid/ready    status[1:0], read_value[63:0] signed, count[10:0]
//
// enqueue, dequeue, read, unused codes and unshifted inserts/deletes go from set-up to result;
// middle inserts/deletes moving k > 0 entries (k up to about count/2) add a shift loop
// and a drain, one storage move per cycle through the single read and single write port
// after reset the queue is empty; storage needs no clearing
// a result waits in the output register; the next item is taken meanwhile and
// holds before its result stage until that register frees
module queue_middle_insert_delete_core #(
	parameter int unsigned DEPTH = qmid_pkg::DEPTH_DEFAULT
) (
	input logic        clk,
	input logic        arst_n,
	qmid_req_if.sink   req,
	qmid_rsp_if.source rsp
);

	qmid_pkg::qmid_cmd_t cmd;
	qmid_pkg::qmid_sts_t sts;

	qmid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	qmid_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_req_type    (req.req_type),
		.in_value       (req.value),
		.in_position    (req.position),
		.out_valid      (rsp.valid),
		.out_ready      (rsp.ready),
		.out_status     (rsp.status),
		.out_read_value (rsp.read_value),
		.out_count      (rsp.count)
	);

endmodule

// ===== hw/rtl/qmid_checker.sv =====
// port-level checks on the queue core and the bind that attaches them
`include "assert_macros.svh"

module qmid_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_valid,
	input logic                                req_ready,
	input logic                                rsp_valid,
	input logic                                rsp_ready,
	input logic [qmid_pkg::ST_W-1:0]           rsp_status,
	input logic signed [qmid_pkg::VALUE_W-1:0] rsp_read_value,
	input logic [qmid_pkg::COUNT_W-1:0]        rsp_count
);

	// a result is held until taken
	`QM_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_count))

	// one item at a time: busy right after an accept
	`QM_ASSERT_NXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready)

	// an empty status always reports zero entries
	`QM_ASSERT_IMP(a_empty_count, clk, arst_n, rsp_valid && (rsp_status == qmid_pkg::ST_EMPTY), rsp_count == '0)

	// read data only on success
	`QM_ASSERT_IMP(a_rdv_zero, clk, arst_n, rsp_valid && (rsp_status != qmid_pkg::ST_OK), rsp_read_value == '0)

endmodule

bind queue_middle_insert_delete_core qmid_checker u_qmid_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_read_value (rsp.read_value),
	.rsp_count      (rsp.count)
);

// ===== verif/tb_queue_middle_insert_delete_core.sv =====
// self-checking testbench for the middle insert/delete queue core with a built-in queue predictor
`timescale 1ns / 1ps

module tb_queue_middle_insert_delete_core;

	localparam int unsigned Q_DEPTH = qmid_pkg::DEPTH_DEFAULT;
	localparam int STUCK_LIMIT = 4000;
	localparam int LONG_HOLD_AT = 500;
	localparam int LONG_HOLD = 400;
	localparam int TAIL_CYCLES = 600;

	localparam logic [qmid_pkg::REQ_W-1:0] REQ_SPARE5 = 3'd5;
	localparam logic [qmid_pkg::REQ_W-1:0] REQ_SPARE6 = 3'd6;
	localparam logic [qmid_pkg::REQ_W-1:0] REQ_SPARE7 = 3'd7;

	localparam logic signed [qmid_pkg::VALUE_W-1:0] VAL_MAX =
		{1'b0, {(qmid_pkg::VALUE_W-1){1'b1}}};
	localparam logic signed [qmid_pkg::VALUE_W-1:0] VAL_MIN =
		{1'b1, {(qmid_pkg::VALUE_W-1){1'b0}}};

	typedef struct {
		logic [qmid_pkg::REQ_W-1:0]          op;
		logic signed [qmid_pkg::VALUE_W-1:0] val;
		logic [qmid_pkg::POS_W-1:0]          pos;
	} q_req_t;

	typedef struct {
		logic [qmid_pkg::ST_W-1:0]           st;
		logic signed [qmid_pkg::VALUE_W-1:0] rd;
		logic [qmid_pkg::COUNT_W-1:0]        cnt;
	} q_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	qmid_req_if req ();
	qmid_rsp_if rsp ();

	queue_middle_insert_delete_core #(
		.DEPTH(Q_DEPTH)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	always #1 clk = ~clk;

	// predicted queue contents
	logic signed [qmid_pkg::VALUE_W-1:0] q_mem [0:Q_DEPTH-1];
	int unsigned q_front;
	int unsigned q_rear;
	bit          q_live;

	q_req_t req_todo [$];
	q_rsp_t rsp_due [$];

	int n_err;
	int n_sent;
	int n_got;
	int stuck;

	function automatic int unsigned held_now();
		return q_live ? q_rear - q_front + 1 : 0;
	endfunction

	function automatic q_rsp_t apply_request(q_req_t r);
		q_rsp_t      res;
		int unsigned p;
		int unsigned m;
		res.st = qmid_pkg::ST_OK;
		res.rd = '0;
		case (r.op)
			qmid_pkg::REQ_ENQ, qmid_pkg::REQ_INS: begin
				if (q_live && q_rear >= Q_DEPTH - 1) begin
					res.st = qmid_pkg::ST_FULL;
				end else if (!q_live) begin
					q_mem[0] = r.val;
					q_front = 0;
					q_rear = 0;
					q_live = 1'b1;
				end else if (r.op == qmid_pkg::REQ_ENQ) begin
					q_rear++;
					q_mem[q_rear] = r.val;
				end else begin
					// later half moves up one slot, new item lands just past the middle
					m = (q_front + q_rear) / 2;
					for (p = q_rear; p > m; p--)
						q_mem[p+1] = q_mem[p];
					q_mem[m+1] = r.val;
					q_rear++;
				end
			end
			qmid_pkg::REQ_DEQ, qmid_pkg::REQ_DEL: begin
				if (!q_live) begin
					res.st = qmid_pkg::ST_EMPTY;
				end else begin
					// middle delete closes the gap by moving the front half up
					if (r.op == qmid_pkg::REQ_DEL)
						for (m = (q_front + q_rear + 1) / 2; m > q_front; m--)
							q_mem[m] = q_mem[m-1];
					if (q_front == q_rear) begin
						q_front = 0;
						q_rear = 0;
						q_live = 1'b0;
					end else begin
						q_front++;
					end
				end
			end
			qmid_pkg::REQ_READ: begin
				if (!q_live)
					res.st = qmid_pkg::ST_EMPTY;
				else if (r.pos >= held_now())
					res.st = qmid_pkg::ST_RANGE;
				else
					res.rd = q_mem[q_front + r.pos];
			end
			default: ;
		endcase
		res.cnt = qmid_pkg::COUNT_W'(held_now());
		return res;
	endfunction

	function automatic logic signed [qmid_pkg::VALUE_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2: return '0;
			3: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [qmid_pkg::REQ_W-1:0] spare_code();
		case ($urandom_range(0, 2))
			0: return REQ_SPARE5;
			1: return REQ_SPARE6;
			default: return REQ_SPARE7;
		endcase
	endfunction

	task automatic add_req(logic [qmid_pkg::REQ_W-1:0] op,
			logic signed [qmid_pkg::VALUE_W-1:0] val, logic [qmid_pkg::POS_W-1:0] pos);
		q_req_t r;
		r.op = op;
		r.val = val;
		r.pos = pos;
		req_todo.push_back(r);
	endtask

	task automatic add_mixed(int n, int push_pct, int pull_pct);
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < push_pct)
				add_req($urandom_range(0, 1) ? qmid_pkg::REQ_ENQ : qmid_pkg::REQ_INS,
					rand_value(), qmid_pkg::POS_W'($urandom));
			else if (pick < push_pct + pull_pct)
				add_req($urandom_range(0, 1) ? qmid_pkg::REQ_DEQ : qmid_pkg::REQ_DEL,
					rand_value(), qmid_pkg::POS_W'($urandom));
			else if (pick < 96)
				add_req(qmid_pkg::REQ_READ, rand_value(), $urandom_range(0, 1) ?
					qmid_pkg::POS_W'($urandom) : qmid_pkg::POS_W'($urandom_range(0, 15)));
			else
				add_req(spare_code(), rand_value(), qmid_pkg::POS_W'($urandom));
		end
	endtask

	task automatic wait_drained();
		while (req_todo.size() != 0 || req.valid !== 1'b0 || rsp_due.size() != 0)
			@(negedge clk);
	endtask

	// request driver
	q_req_t tx_cur;
	bit     tx_busy;
	bit     tx_burst;
	int     tx_gap;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.req_type <= qmid_pkg::REQ_ENQ;
			req.value <= '0;
			req.position <= '0;
			tx_gap = 0;
			tx_burst = 1'b0;
		end else begin
			tx_busy = req.valid;
			if (req.valid && req.ready) begin
				rsp_due.push_back(apply_request(tx_cur));
				tx_busy = 1'b0;
				n_sent++;
				if (n_sent % 64 == 0)
					tx_burst = ($urandom_range(0, 2) == 0);
			end
			if (!tx_busy) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (req_todo.size() != 0) begin
					tx_cur = req_todo.pop_front();
					req.req_type <= tx_cur.op;
					req.value <= tx_cur.val;
					req.position <= tx_cur.pos;
					tx_busy = 1'b1;
					tx_gap = tx_burst ? 0 : $urandom_range(0, 6);
				end
			end
			req.valid <= tx_busy;
		end
	end

	// response monitor and checker
	q_rsp_t want;
	bit     rx_burst;
	int     rx_wait;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			rx_wait = 0;
			rx_burst = 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				n_got++;
				if (rsp_due.size() == 0) begin
					$display("%0t: unexpected item status %0d read_value %h count %0d",
						$realtime, rsp.status, rsp.read_value, rsp.count);
					n_err++;
				end else begin
					want = rsp_due.pop_front();
					if (rsp.status !== want.st) begin
						$display("%0t: status expected %0d got %0d", $realtime, want.st, rsp.status);
						n_err++;
					end
					if (rsp.read_value !== want.rd) begin
						$display("%0t: read_value expected %h got %h",
							$realtime, want.rd, rsp.read_value);
						n_err++;
					end
					if (rsp.count !== want.cnt) begin
						$display("%0t: count expected %0d got %0d", $realtime, want.cnt, rsp.count);
						n_err++;
					end
				end
				rx_wait = rx_burst ? 0 : $urandom_range(0, 6);
				// one long back-pressure stretch so the core backs up into its input
				if (n_got == LONG_HOLD_AT)
					rx_wait = LONG_HOLD;
				if (n_got % 80 == 0)
					rx_burst = ($urandom_range(0, 2) == 0);
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			rsp.ready <= (rx_wait == 0);
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			stuck = 0;
		else
			stuck++;
		if (stuck >= STUCK_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $realtime, stuck);
			$display("tb_queue_middle_insert_delete_core NOT OK");
			$finish;
		end
	end

	initial begin
		int unsigned pushes;
		int          pick;
		int unsigned left;
		req.valid = 1'b0;
		req.req_type = qmid_pkg::REQ_ENQ;
		req.value = '0;
		req.position = '0;
		rsp.ready = 1'b0;
		arst_n = 1'b0;
		q_front = 0;
		q_rear = 0;
		q_live = 1'b0;
		n_err = 0;
		n_sent = 0;
		n_got = 0;
		stuck = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty queue corner cases
		add_req(qmid_pkg::REQ_DEQ, VAL_MAX, '0);
		add_req(qmid_pkg::REQ_DEL, VAL_MIN, '0);
		add_req(qmid_pkg::REQ_READ, '0, '0);
		add_req(REQ_SPARE5, '1, '1);
		// first item through a middle insert, then mixed growth
		add_req(qmid_pkg::REQ_INS, VAL_MAX, '0);
		add_req(qmid_pkg::REQ_ENQ, VAL_MIN, '0);
		add_req(qmid_pkg::REQ_ENQ, '1, '1);
		add_req(qmid_pkg::REQ_INS, '0, '0);
		add_req(qmid_pkg::REQ_INS, 64'sh5A5A_A5A5_0F0F_F0F0, '0);
		for (int i = 0; i < 5; i++)
			add_req(qmid_pkg::REQ_READ, '0, qmid_pkg::POS_W'(i));
		add_req(qmid_pkg::REQ_READ, '0, qmid_pkg::POS_W'(5));
		add_req(qmid_pkg::REQ_READ, '0, '1);
		add_req(REQ_SPARE6, VAL_MIN, '1);
		add_req(REQ_SPARE7, VAL_MAX, '0);
		// shrink to empty, last item removed by a middle delete
		add_req(qmid_pkg::REQ_DEL, '0, '0);
		add_req(qmid_pkg::REQ_DEQ, '0, '0);
		add_req(qmid_pkg::REQ_DEL, '0, '0);
		add_req(qmid_pkg::REQ_DEL, '0, '0);
		add_req(qmid_pkg::REQ_DEL, '0, '0);
		wait_drained();

		// light random traffic around a small queue
		add_mixed(40, 45, 35);
		wait_drained();

		// sender pause above, now empty the queue so the fill starts from slot zero
		left = held_now();
		repeat (left) add_req(qmid_pkg::REQ_DEQ, rand_value(), qmid_pkg::POS_W'($urandom));
		wait_drained();

		// fill until rear hits the last slot, with a few pushes rejected as full
		pushes = 0;
		while (pushes < Q_DEPTH + 6) begin
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				add_req(spare_code(), rand_value(), qmid_pkg::POS_W'($urandom));
			end else if (pick < 6) begin
				add_req(qmid_pkg::REQ_READ, rand_value(), (pick < 3) ?
					qmid_pkg::POS_W'($urandom) : qmid_pkg::POS_W'($urandom_range(0, pushes)));
			end else begin
				add_req((pick < 53) ? qmid_pkg::REQ_ENQ : qmid_pkg::REQ_INS, rand_value(),
					qmid_pkg::POS_W'($urandom));
				pushes++;
			end
		end
		wait_drained();

		// full queue with the front moving: removals, reads, rejected pushes
		add_mixed(40, 15, 55);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_err == 0 && rsp_due.size() == 0)
			$display("tb_queue_middle_insert_delete_core OK");
		else
			$display("tb_queue_middle_insert_delete_core NOT OK");
		$finish;
	end

endmodule
